// ----- rtl/bds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_pkg
// Shared widths, register indexes, state codes and control records of the
// block difference scorer.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int CHAN_W   = 8;
  localparam int REGION_W = 2;
  localparam int TOL_W    = 10;
  localparam int UNIT_W   = TOL_W + 1;
  localparam int CNT_W    = 15;
  localparam int SCORE_W  = 4;
  localparam int ACC_W    = 18;
  localparam int T_W      = 16;
  localparam int TSQ_W    = 32;
  localparam int K_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;

  // Saturation point of every block counter.
  localparam int MAX_BLOCKS = 16384;
  localparam logic [CNT_W-1:0] CNT_CAP =
    CNT_W'((MAX_BLOCKS < 32767) ? MAX_BLOCKS : 32767);

  localparam logic [SCORE_W-1:0] SCORE_MAX   = 4'd9;
  localparam logic [SCORE_W-1:0] SCORE_EIGHT = 4'd8;
  localparam logic [SCORE_W-1:0] SCORE_SEVEN = 4'd7;
  localparam logic [K_W-1:0]     K_FIRST     = 4'd1;
  localparam logic [K_W-1:0]     K_LAST      = 4'd9;

  localparam logic [REGION_W-1:0] REGION_EXCLUDED = 2'd0;
  localparam logic [REGION_W-1:0] REGION_PRINT    = 2'd1;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_NINES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EIGHTS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SEVENS = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MULT,
    ST_SQUARE,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic           load_in;
    logic           acc_en;
    logic [1:0]     chan;
    logic           t_en;
    logic           cmp_en;
    logic [K_W-1:0] k;
    logic           write_out;
  } cmd_t;

  typedef struct packed {
    logic excl;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/bds_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_ctrl
// Sequencer: accepts a block pair, steps the three color channels, then the
// nine score thresholds, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bds_pkg::status_t  status,
  output bds_pkg::cmd_t     cmd
);

  bds_pkg::state_t state, state_next;
  logic [1:0] chan, chan_next;
  logic [bds_pkg::K_W-1:0] k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bds_pkg::ST_IDLE;
      chan  <= bds_pkg::CHAN_RED;
      k     <= bds_pkg::K_FIRST;
    end else begin
      state <= state_next;
      chan  <= chan_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next    = state;
    chan_next     = chan;
    k_next        = k;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.chan      = chan;
    cmd.k         = k;
    case (state)
      bds_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          chan_next   = bds_pkg::CHAN_RED;
          k_next      = bds_pkg::K_FIRST;
          state_next  = bds_pkg::ST_DIFF;
        end
      end
      bds_pkg::ST_DIFF: begin
        if (status.excl) begin
          state_next = bds_pkg::ST_WRITE;
        end else begin
          cmd.acc_en = 1'b1;
          if (chan == bds_pkg::CHAN_BLUE) begin
            state_next = bds_pkg::ST_MULT;
          end else begin
            chan_next = chan + 2'd1;
          end
        end
      end
      bds_pkg::ST_MULT: begin
        cmd.t_en   = 1'b1;
        state_next = bds_pkg::ST_SQUARE;
      end
      bds_pkg::ST_SQUARE: begin
        cmd.cmp_en = 1'b1;
        if (k == bds_pkg::K_LAST) begin
          state_next = bds_pkg::ST_WRITE;
        end else begin
          k_next     = k + 4'd1;
          state_next = bds_pkg::ST_MULT;
        end
      end
      bds_pkg::ST_WRITE: begin
        if (status.out_free) begin
          cmd.write_out = 1'b1;
          state_next    = bds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bds_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/bds_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_datapath
// Input and configuration registers, squared-distance accumulator, threshold
// compare, block counters and the output register.
// ----------------------------------------------------------------------------
module bds_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  bds_pkg::cmd_t                       cmd,
  output bds_pkg::status_t                    status,
  input  logic [bds_pkg::IN_DATA_W-1:0]       in_data,
  input  logic [bds_pkg::REGION_W-1:0]        in_region,
  input  logic                                in_last,
  input  logic                                cfg_en,
  input  logic [bds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bds_pkg::SCORE_W-1:0]         score_o,
  output logic                                excluded_o,
  output logic                                frame_done_o,
  output logic                                fail_o,
  output logic [bds_pkg::CNT_W-1:0]           nines_seen,
  output logic [bds_pkg::CNT_W-1:0]           eights_seen,
  output logic [bds_pkg::CNT_W-1:0]           sevens_seen,
  output logic [bds_pkg::CNT_W-1:0]           excluded_seen
);

  logic [bds_pkg::IN_DATA_W-1:0]  pix;
  logic [bds_pkg::REGION_W-1:0]   region;
  logic                           last;
  logic [bds_pkg::TOL_W-1:0]      tolerance;
  logic [bds_pkg::CNT_W-1:0]      limit_nines, limit_eights, limit_sevens;
  logic [bds_pkg::ACC_W-1:0]      acc;
  logic [bds_pkg::T_W-1:0]        t;
  logic [bds_pkg::SCORE_W-1:0]    score;
  logic [bds_pkg::CNT_W-1:0]      nine_count, eight_count, seven_count, excluded_count;

  logic                           excl;
  logic [bds_pkg::CHAN_W-1:0]     ch_a, ch_b, diff;
  logic [15:0]                    diff_sq;
  logic [bds_pkg::UNIT_W-1:0]     unit;
  logic [4:0]                     odd;
  logic [bds_pkg::TSQ_W-1:0]      tsq, dist4;
  logic [bds_pkg::CNT_W-1:0]      n9_next, n8_next, n7_next, nx_next;
  logic                           fail_next;

  function automatic logic [bds_pkg::CNT_W-1:0] sat_inc(input logic [bds_pkg::CNT_W-1:0] c);
    sat_inc = (c < bds_pkg::CNT_CAP) ? c + 15'd1 : bds_pkg::CNT_CAP;
  endfunction

  assign excl = (region == bds_pkg::REGION_EXCLUDED);
  assign status.excl     = excl;
  assign status.out_free = !out_valid || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance    <= 10'd10;
      limit_nines  <= 15'd0;
      limit_eights <= 15'd10;
      limit_sevens <= 15'd50;
    end else if (cfg_en) begin
      case (cfg_index)
        bds_pkg::CFG_TOLERANCE:    tolerance    <= cfg_data[bds_pkg::TOL_W-1:0];
        bds_pkg::CFG_LIMIT_NINES:  limit_nines  <= cfg_data;
        bds_pkg::CFG_LIMIT_EIGHTS: limit_eights <= cfg_data;
        bds_pkg::CFG_LIMIT_SEVENS: limit_sevens <= cfg_data;
        default: ;
      endcase
    end
  end

  // Channel select and absolute difference, one channel per step
  always_comb begin
    case (cmd.chan)
      bds_pkg::CHAN_RED: begin
        ch_a = pix[7:0];
        ch_b = pix[31:24];
      end
      bds_pkg::CHAN_GREEN: begin
        ch_a = pix[15:8];
        ch_b = pix[39:32];
      end
      default: begin
        ch_a = pix[23:16];
        ch_b = pix[47:40];
      end
    endcase
    diff    = (ch_a > ch_b) ? ch_a - ch_b : ch_b - ch_a;
    diff_sq = 16'(diff) * 16'(diff);
  end

  assign unit  = (region == bds_pkg::REGION_PRINT) ? {tolerance, 1'b0} : {1'b0, tolerance};
  assign odd   = {cmd.k, 1'b0} - 5'd1;
  assign tsq   = bds_pkg::TSQ_W'(t) * bds_pkg::TSQ_W'(t);
  assign dist4 = bds_pkg::TSQ_W'({acc, 2'b00});

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pix    <= in_data;
      region <= in_region;
      last   <= in_last;
      acc    <= '0;
      score  <= '0;
    end else begin
      if (cmd.acc_en) begin
        acc <= acc + bds_pkg::ACC_W'(diff_sq);
      end
      if (cmd.cmp_en && (dist4 >= tsq)) begin
        score <= score + 4'd1;
      end
    end
    if (cmd.t_en) begin
      t <= bds_pkg::T_W'(odd) * bds_pkg::T_W'(unit);
    end
  end

  // Counter update for the block being written out
  always_comb begin
    n9_next = nine_count;
    n8_next = eight_count;
    n7_next = seven_count;
    nx_next = excluded_count;
    if (excl) begin
      nx_next = sat_inc(excluded_count);
    end else if (score == bds_pkg::SCORE_MAX) begin
      n9_next = sat_inc(nine_count);
    end else if (score == bds_pkg::SCORE_EIGHT) begin
      n8_next = sat_inc(eight_count);
    end else if (score == bds_pkg::SCORE_SEVEN) begin
      n7_next = sat_inc(seven_count);
    end
    fail_next = last && ((n9_next > limit_nines) || (n8_next > limit_eights)
                      || (n7_next > limit_sevens));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nine_count     <= '0;
      eight_count    <= '0;
      seven_count    <= '0;
      excluded_count <= '0;
    end else if (cmd.write_out) begin
      nine_count     <= last ? '0 : n9_next;
      eight_count    <= last ? '0 : n8_next;
      seven_count    <= last ? '0 : n7_next;
      excluded_count <= last ? '0 : nx_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      score_o       <= excl ? '0 : score;
      excluded_o    <= excl;
      frame_done_o  <= last;
      fail_o        <= fail_next;
      nines_seen    <= n9_next;
      eights_seen   <= n8_next;
      sevens_seen   <= n7_next;
      excluded_seen <= nx_next;
    end
  end

  a_write_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.write_out |-> (!out_valid || out_ready))
    else $error("result written over a pending result");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !excluded_o) |-> (score_o <= bds_pkg::SCORE_MAX))
    else $error("score above cap");

  a_excluded_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && excluded_o) |-> (score_o == '0))
    else $error("excluded block carries a score");

  a_counters_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.write_out && last) |=> (nine_count == '0 && excluded_count == '0))
    else $error("counters not cleared after last block");

endmodule

// ----- rtl/block_difference_scorer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_difference_scorer
// Scores reference/new block color averages against a tolerance and keeps
// per-frame counts of high scores and excluded blocks.
// ----------------------------------------------------------------------------
//
//  channel | direction | transfer carries
//  --------+-----------+----------------------------------------------------
//  s_*     | in        | one block pair (six color averages, region, last)
//  m_*     | out       | one score result with running counts and verdict
//  cfg_*   | in        | one register write (index, data); always ready
//
//  Steps: a scored block is captured, then its three channel squares are
//  accumulated (one shared 8x8 square and accumulator), then each of nine
//  thresholds takes a threshold multiply step, then a threshold square and
//  compare step, and finally the result is written. An excluded block goes
//  from capture through the difference step straight to the write step.
//  Reset: rst clears the sequencer, the counters, the output valid and loads
//  the register defaults (tolerance 10, limits 0/10/50).
//  Stalls: a finished result waits in the output register while the next
//  block is taken; the sequencer holds in its write step while the output
//  register is still full.
//
module block_difference_scorer (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata, low bit up: ref_red, ref_green, ref_blue, new_red, new_green, new_blue
  input  logic [bds_pkg::IN_DATA_W-1:0]       s_tdata,
  // s_tuser: region_class
  input  logic [bds_pkg::REGION_W-1:0]        s_tuser,
  input  logic                                s_tlast,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // m_tdata, low bit up: score, fail, nines_seen, eights_seen, sevens_seen,
  // excluded_seen, zero fill
  output logic [bds_pkg::OUT_DATA_W-1:0]      m_tdata,
  // m_tuser: excluded
  output logic                                m_tuser,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bds_pkg::cmd_t    cmd;
  bds_pkg::status_t status;

  logic [bds_pkg::SCORE_W-1:0] score;
  logic                        fail;
  logic [bds_pkg::CNT_W-1:0]   nines_seen, eights_seen, sevens_seen, excluded_seen;

  // Register writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  bds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bds_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_data       (s_tdata),
    .in_region     (s_tuser),
    .in_last       (s_tlast),
    .cfg_en        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .score_o       (score),
    .excluded_o    (m_tuser),
    .frame_done_o  (m_tlast),
    .fail_o        (fail),
    .nines_seen    (nines_seen),
    .eights_seen   (eights_seen),
    .sevens_seen   (sevens_seen),
    .excluded_seen (excluded_seen)
  );

  // Pack result fields, score in the low nibble, zero fill to whole bytes.
  assign m_tdata = {7'd0, excluded_seen, sevens_seen, eights_seen, nines_seen, fail, score};

endmodule
